@@ hdl/peval_pkg.sv @@
// ----------------------------------------------------------------------------
// peval_pkg
// Shared types and constants for the polynomial evaluator.
// ----------------------------------------------------------------------------
package peval_pkg;

  localparam int DATA_W        = 32;
  localparam int CNT_W         = 3;
  localparam int IDX_W         = 3;
  localparam int COEF_REGS     = 7;
  localparam int MAX_TERMS_DEF = 7;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [IDX_W-1:0] REG_TERM_COUNT = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_BASE  = 3'd1;

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] acc;
    logic                     sat;
  } word_t;

endpackage

@@ hdl/peval_in_if.sv @@
// ----------------------------------------------------------------------------
// peval_in_if
// Valid/ready channel carrying one evaluation point per word.
// ----------------------------------------------------------------------------
interface peval_in_if;
  import peval_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

@@ hdl/peval_out_if.sv @@
// ----------------------------------------------------------------------------
// peval_out_if
// Valid/ready channel carrying one polynomial value and its flag per word.
// ----------------------------------------------------------------------------
interface peval_out_if;
  import peval_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] y_value;
  logic                     saturated;

  modport source (output valid, output y_value, output saturated, input ready);
  modport sink   (input valid, input y_value, input saturated, output ready);
endinterface

@@ hdl/peval_cell.sv @@
// ----------------------------------------------------------------------------
// peval_cell
// One Horner step: acc * x, floor shift, clamp, add coefficient, clamp.
// Two register stages (multiply, then shift/add) with local valid/ready.
// ----------------------------------------------------------------------------
module peval_cell #(
  parameter int FRAC_BITS = peval_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [peval_pkg::DATA_W-1:0] coef,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  peval_pkg::word_t                    in_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output peval_pkg::word_t                    out_word
);
  import peval_pkg::*;

  localparam int PROD_W = 2 * DATA_W;

  logic                     va;
  logic                     vb;
  logic                     ready_a;
  logic                     ready_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [DATA_W-1:0] x_a;
  logic                     sat_a;
  logic signed [PROD_W-1:0] shifted;
  logic                     prod_ovf;
  logic signed [DATA_W-1:0] prod_sat;
  logic        [DATA_W:0]   sum;
  logic                     sum_ovf;
  logic signed [DATA_W-1:0] acc_next;
  word_t                    word_b;

  assign ready_b  = !vb || out_ready;
  assign ready_a  = !va || ready_b;
  assign in_ready = ready_a;

  // arithmetic shift of the exact product rounds toward minus infinity
  assign shifted  = prod >>> FRAC_BITS;
  assign prod_ovf = !((&shifted[PROD_W-1:DATA_W-1]) || !(|shifted[PROD_W-1:DATA_W-1]));
  assign prod_sat = prod_ovf ? (shifted[PROD_W-1] ? S_MIN : S_MAX) : shifted[DATA_W-1:0];
  assign sum      = {prod_sat[DATA_W-1], prod_sat} + {coef[DATA_W-1], coef};
  assign sum_ovf  = sum[DATA_W] ^ sum[DATA_W-1];
  assign acc_next = sum_ovf ? (sum[DATA_W] ? S_MIN : S_MAX) : sum[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (ready_a) begin
        va <= in_valid;
      end
      if (ready_b) begin
        vb <= va;
      end
    end
    if (ready_a && in_valid) begin
      prod  <= PROD_W'(in_word.acc) * PROD_W'(in_word.x);
      x_a   <= in_word.x;
      sat_a <= in_word.sat;
    end
    if (ready_b && va) begin
      word_b.x   <= x_a;
      word_b.acc <= acc_next;
      word_b.sat <= sat_a || prod_ovf || sum_ovf;
    end
  end

  assign out_valid = vb;
  assign out_word  = word_b;

  a_prod_hold: assert property (@(posedge clk) disable iff (rst)
    va && !ready_b |=> va && $stable(prod))
    else $error("multiply stage lost or changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    vb && !out_ready |=> vb && $stable(word_b))
    else $error("cell output changed while stalled");

  a_sat_step: assert property (@(posedge clk) disable iff (rst)
    va && ready_b && (prod_ovf || sum_ovf) |=> vb && word_b.sat)
    else $error("clamp in this step not flagged");

  a_sat_carry: assert property (@(posedge clk) disable iff (rst)
    in_valid && ready_a && in_word.sat |=> va && sat_a)
    else $error("incoming saturation flag dropped");

endmodule

@@ hdl/polynomial_evaluator.sv @@
// ----------------------------------------------------------------------------
// polynomial_evaluator
// Horner evaluation of a configurable polynomial in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one x word per cycle and returns f(x) one word per cycle, in order,
// unless result.ready holds back the chain. The datapath is a row of
// MAX_TERMS Horner cells, one per coefficient from the highest down; each
// cell has one 32x32 multiplier and two register stages, followed by the
// output register. Coefficients at or above term_count are fed as zero, which
// leaves the accumulator at zero until the leading term enters. Write the
// configuration only while no word is in flight.
module polynomial_evaluator #(
  parameter int MAX_TERMS = peval_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = peval_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [peval_pkg::IDX_W-1:0]         cfg_index,
  input  logic [peval_pkg::DATA_W-1:0]        cfg_data,
  peval_in_if.sink                            sample,
  peval_out_if.source                         result
);
  import peval_pkg::*;

  logic        [CNT_W-1:0]  term_count;
  logic signed [DATA_W-1:0] coefs [COEF_REGS];

  logic                     chain_valid [MAX_TERMS+1];
  logic                     chain_ready [MAX_TERMS+1];
  word_t                    chain_word  [MAX_TERMS+1];

  logic                     out_valid;
  logic signed [DATA_W-1:0] y_value;
  logic                     saturated;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= '0;
      for (int i = 0; i < COEF_REGS; i++) begin
        coefs[i] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == REG_TERM_COUNT) begin
        term_count <= cfg_data[CNT_W-1:0];
      end else begin
        coefs[IDX_W'(cfg_index - REG_COEF_BASE)] <= cfg_data;
      end
    end
  end

  assign chain_valid[0]    = sample.valid;
  assign sample.ready      = chain_ready[0];
  assign chain_word[0].x   = sample.x_value;
  assign chain_word[0].acc = '0;
  assign chain_word[0].sat = 1'b0;

  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_cell
    localparam int CI = MAX_TERMS - 1 - k;
    logic signed [DATA_W-1:0] coef_used;

    assign coef_used = (term_count > CNT_W'(CI)) ? coefs[CI] : '0;

    peval_cell #(
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .coef      (coef_used),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_word   (chain_word[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_word  (chain_word[k+1])
    );
  end

  // output register
  assign chain_ready[MAX_TERMS] = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (chain_ready[MAX_TERMS]) begin
      out_valid <= chain_valid[MAX_TERMS];
    end
    if (chain_ready[MAX_TERMS] && chain_valid[MAX_TERMS]) begin
      y_value   <= chain_word[MAX_TERMS].acc;
      saturated <= chain_word[MAX_TERMS].sat;
    end
  end

  assign result.valid     = out_valid;
  assign result.y_value   = y_value;
  assign result.saturated = saturated;

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Horner polynomial evaluator.
// Loads a series of term counts and coefficient sets and streams Q16.16
// points through the valid/ready channels. Both channels idle at random.
// Every result word is checked against a fixed-point Horner predictor that
// saturates each step. A directed part covers the field extremes, empty and
// single-term polynomials, floor rounding and saturation. Random phases follow.
// ----------------------------------------------------------------------------
module tb_top;
  import peval_pkg::*;

  localparam int          PHASES         = 11;
  localparam int          POINTS_PER_SET = 50;
  localparam int unsigned POINT_SPAN     = 32'h0004_0000;  // +-4.0
  localparam int unsigned COEF_SPAN      = 32'h0002_0000;  // +-2.0
  localparam int          LONG_HOLD      = 120;
  localparam int          STALL_LIMIT    = 2000;
  localparam longint      S32_HI         = 64'sd2147483647;
  localparam longint      S32_LO         = -64'sd2147483648;

  typedef struct packed {
    logic [DATA_W-1:0] y;
    logic              sat;
  } poly_value_t;

  class horner_scoreboard;
    logic [CNT_W-1:0]  terms;
    logic [DATA_W-1:0] coef [COEF_REGS];
    poly_value_t       awaited [$];
    int                errors;
    int                points;
    int                results;
    int                clamped;

    function new();
      terms = '0;
      foreach (coef[i]) coef[i] = '0;
      errors  = 0;
      points  = 0;
      results = 0;
      clamped = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      if (idx == REG_TERM_COUNT)
        terms = data[CNT_W-1:0];
      else
        coef[int'(idx) - int'(REG_COEF_BASE)] = data;
    endfunction

    function longint clamp(longint v, inout logic flag);
      if (v > S32_HI) begin
        flag = 1'b1;
        return S32_HI;
      end
      if (v < S32_LO) begin
        flag = 1'b1;
        return S32_LO;
      end
      return v;
    endfunction

    function poly_value_t horner(logic [DATA_W-1:0] x);
      poly_value_t r;
      longint      acc;
      longint      xs;
      int          n;
      int          i;
      logic        flag;
      n    = (terms > MAX_TERMS_DEF) ? MAX_TERMS_DEF : int'(terms);
      xs   = longint'($signed(x));
      acc  = 0;
      flag = 1'b0;
      if (n > 0) begin
        acc = longint'($signed(coef[n-1]));
        for (i = n - 2; i >= 0; i--) begin
          acc = clamp((acc * xs) >>> FRAC_BITS_DEF, flag);
          acc = clamp(acc + longint'($signed(coef[i])), flag);
        end
      end
      r.y   = acc[DATA_W-1:0];
      r.sat = flag;
      return r;
    endfunction

    function void note_point(logic [DATA_W-1:0] x);
      poly_value_t v;
      v = horner(x);
      awaited = {awaited, v};
      points++;
      if (v.sat) clamped++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("mismatch: %s", msg);
    endtask

    task check_value(logic [DATA_W-1:0] y, logic sat);
      poly_value_t want;
      results++;
      if (awaited.size() == 0) begin
        report($sformatf("result word y=%h sat=%b with nothing pending", y, sat));
        return;
      end
      want = awaited.pop_front();
      if (y !== want.y)
        report($sformatf("word %0d: y=%h, predicted %h", results, y, want.y));
      if (sat !== want.sat)
        report($sformatf("word %0d: saturated=%b, predicted %b", results, sat, want.sat));
    endtask
  endclass

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  bit                calm = 1'b0;
  bit                hold_request = 1'b0;
  int                idle_cycles = 0;
  int                settings_used = 0;
  int                next_terms;
  logic [DATA_W-1:0] next_coef [COEF_REGS];
  horner_scoreboard  keeper;

  peval_in_if  sample_bus ();
  peval_out_if result_bus ();

  polynomial_evaluator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_bus),
    .result    (result_bus)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && sample_bus.valid && sample_bus.ready)
      keeper.note_point(sample_bus.x_value);
    if (!rst && result_bus.valid && result_bus.ready)
      keeper.check_value(result_bus.y_value, result_bus.saturated);
  end

  always @(posedge clk) begin
    if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no word moved for %0d cycles", STALL_LIMIT);
      $display("[polynomial_evaluator] ERROR");
      $finish;
    end
  end

  // result side: random back-pressure, one long hold on request
  initial begin
    result_bus.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        result_bus.ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        result_bus.ready = 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end else begin
        result_bus.ready = 1'b1;
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_q16(int unsigned span, bit edges_only);
    int unsigned roll;
    roll = edges_only ? 19 : $urandom_range(0, 19);
    if (roll < 12) return $urandom_range(0, 2 * span) - span;
    if (roll < 17) return $urandom;
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 32'h0000_0001;
      2: return '1;
      3: return S_MAX;
      4: return S_MIN;
      5: return 32'h0001_0000;
      default: return 32'hFFFF_0000;
    endcase
  endfunction

  task automatic put_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    keeper.write_reg(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic apply_setting();
    int i;
    put_reg(REG_TERM_COUNT, DATA_W'(next_terms));
    for (i = 0; i < COEF_REGS; i++)
      put_reg(IDX_W'(int'(REG_COEF_BASE) + i), next_coef[i]);
    settings_used++;
  endtask

  task automatic send_point(logic [DATA_W-1:0] v);
    if (!calm && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 10)) begin
        @(negedge clk);
        sample_bus.valid = 1'b0;
      end
    end
    @(negedge clk);
    sample_bus.valid   = 1'b1;
    sample_bus.x_value = v;
    do @(posedge clk); while (!sample_bus.ready);
  endtask

  // stop offering and wait for every pending word
  task automatic settle();
    @(negedge clk);
    sample_bus.valid = 1'b0;
    while (keeper.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    int p;
    int i;
    keeper = new();
    sample_bus.valid   = 1'b0;
    sample_bus.x_value = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty polynomial
    next_terms = 0;
    for (i = 0; i < COEF_REGS; i++) next_coef[i] = 32'h1111_0000 * (i + 1);
    apply_setting();
    send_point('0);
    send_point(S_MAX);
    send_point(S_MIN);
    settle();

    // single term
    next_terms   = 1;
    next_coef[0] = S_MIN;
    for (i = 1; i < COEF_REGS; i++) next_coef[i] = S_MAX;
    apply_setting();
    send_point(S_MAX);
    send_point(S_MIN);
    send_point(32'h0001_0000);
    settle();

    // 1 + 2x - 0.5x^2, with the smallest steps of x for floor rounding
    next_terms   = 3;
    next_coef[0] = 32'h0001_0000;
    next_coef[1] = 32'h0002_0000;
    next_coef[2] = 32'hFFFF_8000;
    apply_setting();
    send_point(32'h0001_0000);
    send_point(32'hFFFF_0000);
    send_point('1);
    send_point(32'h0000_0001);
    send_point(32'h0003_0000);
    settle();

    // full degree, saturating both ways
    next_terms = MAX_TERMS_DEF;
    for (i = 0; i < COEF_REGS; i++) next_coef[i] = S_MAX;
    apply_setting();
    send_point(S_MAX);
    send_point(S_MIN);
    send_point(32'h0001_0000);
    settle();
    for (i = 0; i < COEF_REGS; i++) next_coef[i] = S_MIN;
    apply_setting();
    send_point(S_MIN);
    send_point(S_MAX);
    send_point(32'hFFFF_0000);
    settle();

    // negative product below one lsb rounds down to -1
    next_terms = 2;
    for (i = 0; i < COEF_REGS; i++) next_coef[i] = '0;
    next_coef[1] = '1;
    apply_setting();
    send_point(32'h0000_0001);
    send_point('1);
    send_point(S_MAX);
    settle();

    for (p = 0; p < PHASES; p++) begin
      calm = (p == PHASES - 1);
      if (p == 0 || p == 2)
        next_terms = MAX_TERMS_DEF;
      else if (p == 1)
        next_terms = 0;
      else
        next_terms = $urandom_range(0, MAX_TERMS_DEF);
      for (i = 0; i < COEF_REGS; i++) next_coef[i] = pick_q16(COEF_SPAN, p == 2);
      apply_setting();
      if (p == 3) hold_request = 1'b1;
      repeat (POINTS_PER_SET) send_point(pick_q16(POINT_SPAN, 1'b0));
      settle();
    end

    repeat (2 * MAX_TERMS_DEF + 5) @(posedge clk);
    if (keeper.awaited.size() != 0)
      keeper.report($sformatf("%0d words never came out", keeper.awaited.size()));
    $display("evaluated %0d points over %0d coefficient sets, %0d of them saturating",
             keeper.points, settings_used, keeper.clamped);
    $display("checked %0d result words with random stalls on both channels",
             keeper.results);
    if (keeper.errors == 0)
      $display("[polynomial_evaluator] OK");
    else
      $display("[polynomial_evaluator] ERROR");
    $finish;
  end

endmodule
